// ===== hdl/dhpc_pkg.sv =====
// Package for the dew heater power control unit: register indexes, result codes,
// Magnus constants, ln step table and the structs between the arithmetic units.
// No dependencies.
package dhpc_pkg;

    localparam int NUM_W = 48;   // divider dividend / quotient width
    localparam int DEN_W = 32;   // divider divisor width
    localparam int CNT_W = 6;    // holds NUM_W

    localparam logic [2:0] REG_HEATER1_LIMIT = 3'd0;
    localparam logic [2:0] REG_HEATER2_LIMIT = 3'd1;
    localparam logic [2:0] REG_INTERVAL_MS   = 3'd2;
    localparam logic [2:0] REG_START_DELTA   = 3'd3;
    localparam logic [2:0] REG_FULL_ON_DELTA = 3'd4;

    localparam logic [1:0] RC_OK       = 2'd0;
    localparam logic [1:0] RC_ABSENT   = 2'd1;
    localparam logic [1:0] RC_INVALID  = 2'd2;
    localparam logic [1:0] RC_HUM_HIGH = 2'd3;

    localparam logic [15:0] INTERVAL_RESET = 16'd5000;
    localparam logic [10:0] START_RESET    = 11'd400;
    localparam logic [10:0] FULL_ON_RESET  = 11'd200;

    localparam logic [16:0] HUM_FULL   = 17'd102400;
    localparam logic [15:0] LN2_Q16    = 16'd45426;
    localparam logic [6:0]  LIM_MAX    = 7'd100;
    localparam logic [16:0] MAGNUS_B   = 17'd24312;
    localparam logic [10:0] MAGNUS_A   = 11'd1762;
    localparam logic [21:0] TD_SCALE   = 22'd2431200;
    localparam logic [26:0] TD_BASE    = 27'd115474432;  // 1762 * 65536
    localparam logic [14:0] TD_MIN_MAG = 15'd10000;
    localparam logic [14:0] TD_MAX     = 15'd16383;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic        done;
        logic [16:0] acc;
        logic [4:0]  e;
        logic [30:0] t;
        logic [30:0] p;
    } ln_rsp_t;

    // ln(1 + 2^-(idx+1)) in Q16
    function automatic logic [14:0] ln_step(input logic [3:0] idx);
        logic [14:0] v;
        unique case (idx)
            4'd0:  v = 15'd26573;
            4'd1:  v = 15'd14624;
            4'd2:  v = 15'd7719;
            4'd3:  v = 15'd3973;
            4'd4:  v = 15'd2017;
            4'd5:  v = 15'd1016;
            4'd6:  v = 15'd510;
            4'd7:  v = 15'd256;
            4'd8:  v = 15'd128;
            4'd9:  v = 15'd64;
            4'd10: v = 15'd32;
            4'd11: v = 15'd16;
            4'd12: v = 15'd8;
            4'd13: v = 15'd4;
            4'd14: v = 15'd2;
            4'd15: v = 15'd1;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/dhpc_in_if.sv =====
// Sample channel interface of the dew heater power control unit.
// Depends on nothing.
interface dhpc_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic               sensor_present;
    logic               reading_valid;
    logic signed [14:0] temperature;
    logic [16:0]        humidity;

    modport source (output valid, now_ms, sensor_present, reading_valid, temperature,
                    humidity, input ready);
    modport sink (input valid, now_ms, sensor_present, reading_valid, temperature,
                  humidity, output ready);
endinterface

// ===== hdl/dhpc_out_if.sv =====
// Result channel interface of the dew heater power control unit.
// Depends on nothing.
interface dhpc_out_if;
    logic               valid;
    logic               ready;
    logic [6:0]         heater1_power;
    logic [6:0]         heater2_power;
    logic               heating_active;
    logic signed [14:0] dew_point;
    logic [1:0]         result_code;

    modport source (output valid, heater1_power, heater2_power, heating_active,
                    dew_point, result_code, input ready);
    modport sink (input valid, heater1_power, heater2_power, heating_active,
                  dew_point, result_code, output ready);
endinterface

// ===== hdl/dew_heater_power_control_unit.sv =====
// An accepted sample whose dew point is computed goes through the one-bit-per-cycle divider
// run six times (g1, two log corrections, dew point, two heater powers) and the serial log
// normalise; a rejected reading goes straight to the result state; an early sample gives
// no result. One sample is worked at a time: the next is taken the cycle after the result
// is loaded, and output stalls hold off that load.
// Reset (async, active low) restores register defaults and clears the last time.
module dew_heater_power_control_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    dhpc_in_if.sink     in_ch,
    dhpc_out_if.source  out_ch
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_G1      = 4'd1;
    localparam logic [3:0] S_LNH     = 4'd2;
    localparam logic [3:0] S_LNH_DIV = 4'd3;
    localparam logic [3:0] S_LNF     = 4'd4;
    localparam logic [3:0] S_LNF_DIV = 4'd5;
    localparam logic [3:0] S_TD_MUL  = 4'd6;
    localparam logic [3:0] S_TD_DIV  = 4'd7;
    localparam logic [3:0] S_P1      = 4'd8;
    localparam logic [3:0] S_P2      = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [6:0]  h1_lim_reg, h2_lim_reg;
    logic [15:0] interval_reg;
    logic [10:0] start_reg, fod_reg;
    logic [31:0] last_reg;

    logic [3:0]  state_reg;
    logic        kick_reg;
    logic        ov_reg;

    logic [14:0] temp_reg;
    logic [16:0] hum_reg;
    logic [1:0]  code_reg;
    logic [23:0] g1_reg;
    logic [21:0] lnh_reg, lnf_reg;
    logic [43:0] prod_reg;
    logic [28:0] tdden_reg;
    logic        gneg_reg;
    logic [14:0] td_reg;
    logic [6:0]  p1_reg, p2_reg;

    logic [6:0]  o_p1_reg, o_p2_reg;
    logic        o_act_reg;
    logic [14:0] o_td_reg;
    logic [1:0]  o_code_reg;

    dhpc_pkg::div_req_t div_req;
    dhpc_pkg::div_rsp_t div_rsp;
    dhpc_pkg::ln_rsp_t  ln_rsp;
    logic               ln_start;
    logic [16:0]        ln_x;

    logic        accept, early, load_out;
    logic        tneg;
    logic [15:0] tmag;
    logic [16:0] tpos;
    logic [23:0] g1_q, g1_next;
    logic [21:0] ln_val;
    logic [23:0] gamma;
    logic [21:0] gmag;
    logic [29:0] tdden;
    logic [14:0] td_next;
    logic [16:0] delta, start_x, diff;
    logic        active;
    logic [6:0]  lim_raw, lim;
    logic [6:0]  pw;

    dhpc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
    dhpc_ln  u_ln  (.clk(clk), .rst_n(rst_n), .start(ln_start), .x(ln_x), .rsp(ln_rsp));

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign early       = (32'(in_ch.now_ms - last_reg) < {16'd0, interval_reg});
    assign load_out    = (state_reg == S_DONE) && (!ov_reg || out_ch.ready);

    // g1 operands
    assign tneg = temp_reg[14];
    assign tmag = tneg ? (16'd0 - {temp_reg[14], temp_reg}) : {1'b0, temp_reg};
    assign tpos = dhpc_pkg::MAGNUS_B + {{2{temp_reg[14]}}, temp_reg};
    assign g1_q = div_rsp.quo[23:0];
    assign g1_next = tneg ? (24'd0 - g1_q) : g1_q;

    // log result: acc + correction + e * ln2
    assign ln_val = {5'd0, ln_rsp.acc} + div_rsp.quo[21:0]
                  + 22'(22'(ln_rsp.e) * 22'(dhpc_pkg::LN2_Q16));

    // dew point operands
    assign gamma = g1_reg + {2'b0, lnh_reg} - {2'b0, lnf_reg};
    assign gmag  = gamma[23] ? 22'(24'd0 - gamma) : gamma[21:0];
    assign tdden = {3'b0, dhpc_pkg::TD_BASE} - 30'({{6{gamma[23]}}, gamma} * 30'd100);

    always_comb
    begin
        if (gneg_reg)
            td_next = (div_rsp.quo > 48'(dhpc_pkg::TD_MIN_MAG))
                    ? (15'd0 - dhpc_pkg::TD_MIN_MAG) : (15'd0 - div_rsp.quo[14:0]);
        else
            td_next = (div_rsp.quo > 48'(dhpc_pkg::TD_MAX))
                    ? dhpc_pkg::TD_MAX : div_rsp.quo[14:0];
    end

    // heater power; a zero span divides to all ones and clamps to the limit
    assign delta   = {{2{temp_reg[14]}}, temp_reg} - {{2{td_reg[14]}}, td_reg};
    assign start_x = {6'd0, start_reg};
    assign active  = ($signed(delta) < $signed(start_x));
    assign diff    = start_x - delta;
    assign lim_raw = (state_reg == S_P1) ? h1_lim_reg : h2_lim_reg;
    assign lim     = (lim_raw > dhpc_pkg::LIM_MAX) ? dhpc_pkg::LIM_MAX : lim_raw;
    assign pw      = !active ? 7'd0
                   : ((div_rsp.quo > 48'(lim)) ? lim : div_rsp.quo[6:0]);

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        ln_start      = 1'b0;
        ln_x          = hum_reg;
        unique case (state_reg)
            S_G1:
            begin
                div_req.start = kick_reg;
                div_req.num   = {6'd0, 26'(26'(tmag) * 26'(dhpc_pkg::MAGNUS_A)), 16'd0};
                div_req.den   = 32'(24'(tpos) * 24'd100);
            end
            S_LNH:
            begin
                ln_start = kick_reg;
                ln_x     = hum_reg;
            end
            S_LNF:
            begin
                ln_start = kick_reg;
                ln_x     = dhpc_pkg::HUM_FULL;
            end
            S_LNH_DIV, S_LNF_DIV:
            begin
                div_req.start = kick_reg;
                div_req.num   = {1'b0, 31'(ln_rsp.t - ln_rsp.p), 16'd0};
                div_req.den   = {1'b0, ln_rsp.p};
            end
            S_TD_DIV:
            begin
                div_req.start = kick_reg;
                div_req.num   = {4'd0, prod_reg};
                div_req.den   = {3'd0, tdden_reg};
            end
            S_P1, S_P2:
            begin
                div_req.start = kick_reg;
                div_req.num   = 48'(24'(lim) * 24'(diff));
                div_req.den   = {21'd0, fod_reg};
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_lim_reg   <= '0;
            h2_lim_reg   <= '0;
            interval_reg <= dhpc_pkg::INTERVAL_RESET;
            start_reg    <= dhpc_pkg::START_RESET;
            fod_reg      <= dhpc_pkg::FULL_ON_RESET;
            last_reg     <= '0;
            state_reg    <= S_IDLE;
            kick_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dhpc_pkg::REG_HEATER1_LIMIT: h1_lim_reg   <= cfg_data[6:0];
                    dhpc_pkg::REG_HEATER2_LIMIT: h2_lim_reg   <= cfg_data[6:0];
                    dhpc_pkg::REG_INTERVAL_MS:   interval_reg <= cfg_data;
                    dhpc_pkg::REG_START_DELTA:   start_reg    <= cfg_data[10:0];
                    dhpc_pkg::REG_FULL_ON_DELTA: fod_reg      <= cfg_data[10:0];
                    default: ;
                endcase
            end

            kick_reg <= 1'b0;
            if (load_out)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                    if (accept && !early)
                    begin
                        last_reg <= in_ch.now_ms;
                        if (!in_ch.sensor_present || !in_ch.reading_valid
                            || in_ch.humidity == 17'd0
                            || in_ch.humidity > dhpc_pkg::HUM_FULL)
                            state_reg <= S_DONE;
                        else
                        begin
                            state_reg <= S_G1;
                            kick_reg  <= 1'b1;
                        end
                    end
                S_G1:
                    if (div_rsp.done)
                    begin
                        state_reg <= S_LNH;
                        kick_reg  <= 1'b1;
                    end
                S_LNH:
                    if (ln_rsp.done)
                    begin
                        state_reg <= S_LNH_DIV;
                        kick_reg  <= 1'b1;
                    end
                S_LNH_DIV:
                    if (div_rsp.done)
                    begin
                        state_reg <= S_LNF;
                        kick_reg  <= 1'b1;
                    end
                S_LNF:
                    if (ln_rsp.done)
                    begin
                        state_reg <= S_LNF_DIV;
                        kick_reg  <= 1'b1;
                    end
                S_LNF_DIV:
                    if (div_rsp.done)
                        state_reg <= S_TD_MUL;
                S_TD_MUL:
                begin
                    state_reg <= S_TD_DIV;
                    kick_reg  <= 1'b1;
                end
                S_TD_DIV:
                    if (div_rsp.done)
                    begin
                        state_reg <= S_P1;
                        kick_reg  <= 1'b1;
                    end
                S_P1:
                    if (div_rsp.done)
                    begin
                        state_reg <= S_P2;
                        kick_reg  <= 1'b1;
                    end
                S_P2:
                    if (div_rsp.done)
                        state_reg <= S_DONE;
                S_DONE:
                    if (load_out)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            temp_reg <= in_ch.temperature;
            hum_reg  <= in_ch.humidity;
            td_reg   <= '0;
            p1_reg   <= '0;
            p2_reg   <= '0;
            if (!in_ch.sensor_present)
                code_reg <= dhpc_pkg::RC_ABSENT;
            else if (!in_ch.reading_valid || in_ch.humidity == 17'd0)
                code_reg <= dhpc_pkg::RC_INVALID;
            else if (in_ch.humidity > dhpc_pkg::HUM_FULL)
                code_reg <= dhpc_pkg::RC_HUM_HIGH;
            else
                code_reg <= dhpc_pkg::RC_OK;
        end
        if (state_reg == S_G1 && div_rsp.done)
            g1_reg <= g1_next;
        if (state_reg == S_LNH_DIV && div_rsp.done)
            lnh_reg <= ln_val;
        if (state_reg == S_LNF_DIV && div_rsp.done)
            lnf_reg <= ln_val;
        if (state_reg == S_TD_MUL)
        begin
            prod_reg  <= 44'(gmag) * 44'(dhpc_pkg::TD_SCALE);
            tdden_reg <= tdden[28:0];
            gneg_reg  <= gamma[23];
        end
        if (state_reg == S_TD_DIV && div_rsp.done)
            td_reg <= td_next;
        if (state_reg == S_P1 && div_rsp.done)
            p1_reg <= pw;
        if (state_reg == S_P2 && div_rsp.done)
            p2_reg <= pw;
        if (load_out)
        begin
            o_p1_reg   <= p1_reg;
            o_p2_reg   <= p2_reg;
            o_act_reg  <= (p1_reg != 7'd0) || (p2_reg != 7'd0);
            o_td_reg   <= td_reg;
            o_code_reg <= code_reg;
        end
    end

    assign out_ch.valid          = ov_reg;
    assign out_ch.heater1_power  = o_p1_reg;
    assign out_ch.heater2_power  = o_p2_reg;
    assign out_ch.heating_active = o_act_reg;
    assign out_ch.dew_point      = o_td_reg;
    assign out_ch.result_code    = o_code_reg;
endmodule

// ===== hdl/dhpc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dhpc_pkg.
module dhpc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  dhpc_pkg::div_req_t req,
    output dhpc_pkg::div_rsp_t rsp
);
    logic [dhpc_pkg::CNT_W-1:0] cnt_reg;
    logic                       done_reg;
    logic [dhpc_pkg::NUM_W-1:0] quo_reg;
    logic [dhpc_pkg::DEN_W-1:0] rem_reg;
    logic [dhpc_pkg::DEN_W-1:0] den_reg;
    logic [dhpc_pkg::DEN_W:0]   sh;
    logic                       ge;

    assign sh = {rem_reg, quo_reg[dhpc_pkg::NUM_W-1]};
    assign ge = (sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
                cnt_reg <= dhpc_pkg::CNT_W'(dhpc_pkg::NUM_W);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == dhpc_pkg::CNT_W'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? dhpc_pkg::DEN_W'(sh - {1'b0, den_reg})
                          : sh[dhpc_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[dhpc_pkg::NUM_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

// ===== hdl/dhpc_ln.sv =====
// Natural log front end: serial normalise, then sixteen shift-and-add steps.
// The fractional correction is divided by the shared divider. Depends on dhpc_pkg.
module dhpc_ln (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [16:0]       x,
    output dhpc_pkg::ln_rsp_t rsp
);
    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_STEP = 2'd2;

    logic [1:0]  state_reg;
    logic        done_reg;
    logic [30:0] t_reg;
    logic [30:0] p_reg;
    logic [16:0] acc_reg;
    logic [4:0]  e_reg;
    logic [4:0]  k_reg;
    logic [31:0] q;
    logic        take;

    assign q    = {1'b0, p_reg} + {1'b0, p_reg >> k_reg};
    assign take = (q <= {1'b0, t_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                    if (start)
                        state_reg <= L_NORM;
                L_NORM:
                    if (t_reg[30])
                        state_reg <= L_STEP;
                L_STEP:
                    if (k_reg == 5'd16)
                    begin
                        state_reg <= L_IDLE;
                        done_reg  <= 1'b1;
                    end
                default:
                    state_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && start)
        begin
            t_reg <= {14'd0, x};
            e_reg <= 5'd30;
        end
        else if (state_reg == L_NORM)
        begin
            if (t_reg[30])
            begin
                p_reg   <= 31'h4000_0000;
                k_reg   <= 5'd1;
                acc_reg <= '0;
            end
            else
            begin
                t_reg <= {t_reg[29:0], 1'b0};
                e_reg <= e_reg - 1'b1;
            end
        end
        else if (state_reg == L_STEP)
        begin
            if (take)
            begin
                p_reg   <= q[30:0];
                acc_reg <= acc_reg + {2'b0, dhpc_pkg::ln_step(4'(k_reg - 5'd1))};
            end
            k_reg <= k_reg + 1'b1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.acc  = acc_reg;
    assign rsp.e    = e_reg;
    assign rsp.t    = t_reg;
    assign rsp.p    = p_reg;
endmodule

// ===== hdl/dhpc_checker.sv =====
// Port-level checks for the dew heater power control unit, bound to the top level.
// Depends on dhpc_pkg and dew_heater_power_control_unit.
module dhpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [6:0]  heater1_power,
    input logic [6:0]  heater2_power,
    input logic        heating_active,
    input logic [14:0] dew_point,
    input logic [1:0]  result_code
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heating_active == (heater1_power != 7'd0 || heater2_power != 7'd0))
        else $error("heating_active disagrees with powers");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code != dhpc_pkg::RC_OK
        |-> heater1_power == 7'd0 && heater2_power == 7'd0 && dew_point == 15'd0)
        else $error("error result carries nonzero fields");

    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heater1_power <= 7'd100 && heater2_power <= 7'd100)
        else $error("heater power above 100");
endmodule

bind dew_heater_power_control_unit dhpc_checker u_dhpc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .heater1_power(out_ch.heater1_power),
    .heater2_power(out_ch.heater2_power),
    .heating_active(out_ch.heating_active),
    .dew_point(out_ch.dew_point),
    .result_code(out_ch.result_code)
);

// ===== tb/dhpc_tb_if.sv =====
// Testbench note: the channel interfaces dhpc_in_if and dhpc_out_if are taken from the RTL.
// This file only holds shared testbench constants; depends on nothing.
package dhpc_tb_pkg;
    localparam int SLOW_LATENCY = 450;
endpackage

// ===== tb/tb_dew_heater_power_control_unit.sv =====
// Testbench for the dew heater power control unit: drives samples and register writes,
// predicts each result with an integer dew point model and checks every field in order.
// Depends on dhpc_pkg, dhpc_tb_pkg, dhpc_in_if, dhpc_out_if and the RTL.
module tb_dew_heater_power_control_unit;

    typedef struct packed {
        logic [6:0]         h1;
        logic [6:0]         h2;
        logic               active;
        logic signed [14:0] dew;
        logic [1:0]         code;
    } heater_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = dhpc_pkg::REG_HEATER1_LIMIT;
    logic [15:0] cfg_data = '0;
    int          cycles = 0;
    int          errors = 0;
    int          results_seen = 0;
    int          samples_sent = 0;

    logic [6:0]  m_h1_lim, m_h2_lim;
    logic [15:0] m_interval;
    logic [10:0] m_start, m_full;
    logic [31:0] m_last;
    logic [31:0] clock_ms = '0;

    heater_result_t pending_results[$];

    dhpc_in_if  in_ch();
    dhpc_out_if out_ch();

    dew_heater_power_control_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint log_q16(longint unsigned x);
        int          e;
        longint unsigned t, p, q;
        longint      acc;
        longint      steps[16];
        steps = '{26573, 14624, 7719, 3973, 2017, 1016, 510, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        e = 0;
        acc = 0;
        if (x == 0)
            x = 1;
        while (e < 31 && (x >> (e + 1)) != 0)
            e++;
        if (e > 30)
            e = 30;
        t = x << (30 - e);
        p = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
        begin
            q = p + (p >> k);
            if (q <= t)
            begin
                p = q;
                acc += steps[k - 1];
            end
        end
        acc += longint'(((t - p) << 16) / p);
        return acc + longint'(e) * 45426;
    endfunction

    function automatic logic [6:0] drive_percent(logic [6:0] limit, longint margin);
        longint lim, p;
        lim = (limit > 7'd100) ? 100 : longint'(limit);
        if (margin >= longint'(m_start))
            return 7'd0;
        if (m_full == 11'd0)
            return 7'(lim);
        p = lim * (longint'(m_start) - margin) / longint'(m_full);
        if (p < 0)
            p = 0;
        if (p > lim)
            p = lim;
        return 7'(p);
    endfunction

    // returns 1 when the sample is accepted and yields a result
    function automatic bit predict_heating(logic [31:0] now, logic pres, logic ok,
                                           logic signed [14:0] temp, logic [16:0] hum,
                                           output heater_result_t r);
        longint tc, g1, gam, td;
        r = '0;
        if (32'(now - m_last) < {16'd0, m_interval})
            return 1'b0;
        m_last = now;
        if (!pres)
            r.code = dhpc_pkg::RC_ABSENT;
        else if (!ok || hum == 17'd0)
            r.code = dhpc_pkg::RC_INVALID;
        else if (hum > dhpc_pkg::HUM_FULL)
            r.code = dhpc_pkg::RC_HUM_HIGH;
        else
        begin
            tc = temp;
            g1 = 1762 * tc * 65536 / (100 * (24312 + tc));
            gam = g1 + log_q16(hum) - log_q16(102400);
            td = 2431200 * gam / (115474432 - 100 * gam);
            if (td < -10000)
                td = -10000;
            if (td > 16383)
                td = 16383;
            r.h1 = drive_percent(m_h1_lim, tc - td);
            r.h2 = drive_percent(m_h2_lim, tc - td);
            r.active = (r.h1 != 7'd0) || (r.h2 != 7'd0);
            r.dew = 15'(td);
            r.code = dhpc_pkg::RC_OK;
        end
        return 1'b1;
    endfunction

    // result checker and receiver stalls, mostly short with the odd long one
    initial
    begin
        heater_result_t got, exp_r;
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                stall_left = $urandom_range(20, 60);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 9) >= 3);
            @(posedge clk);
            if (out_ch.valid && out_ch.ready && rst_n)
            begin
                got = '{out_ch.heater1_power, out_ch.heater2_power, out_ch.heating_active,
                        out_ch.dew_point, out_ch.result_code};
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected transaction %p", $time, got);
                    errors++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (got !== exp_r)
                    begin
                        $display("%0t mismatch: expected %p actual %p", $time, exp_r, got);
                        errors++;
                    end
                end
            end
        end
    end

    // valid stays up after the handshake until the next falling edge; a zero gap
    // puts the next transaction straight behind the last one
    task automatic send_sample(logic [31:0] now, logic pres, logic ok,
                               logic signed [14:0] temp, logic [16:0] hum);
        heater_result_t r;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
        @(negedge clk);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.now_ms <= now;
        in_ch.sensor_present <= pres;
        in_ch.reading_valid <= ok;
        in_ch.temperature <= temp;
        in_ch.humidity <= hum;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (predict_heating(now, pres, ok, temp, hum, r))
            pending_results.push_back(r);
        samples_sent++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (dhpc_tb_pkg::SLOW_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dhpc_pkg::REG_HEATER1_LIMIT: m_h1_lim = val[6:0];
            dhpc_pkg::REG_HEATER2_LIMIT: m_h2_lim = val[6:0];
            dhpc_pkg::REG_INTERVAL_MS:   m_interval = val;
            dhpc_pkg::REG_START_DELTA:   m_start = val[10:0];
            dhpc_pkg::REG_FULL_ON_DELTA: m_full = val[10:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [6:0] l1, logic [6:0] l2, logic [15:0] iv,
                              logic [10:0] sd, logic [10:0] fd);
        drain();
        write_reg(dhpc_pkg::REG_HEATER1_LIMIT, {9'd0, l1});
        write_reg(dhpc_pkg::REG_HEATER2_LIMIT, {9'd0, l2});
        write_reg(dhpc_pkg::REG_INTERVAL_MS, iv);
        write_reg(dhpc_pkg::REG_START_DELTA, {5'd0, sd});
        write_reg(dhpc_pkg::REG_FULL_ON_DELTA, {5'd0, fd});
    endtask

    // next timestamp, always past the interval
    function automatic logic [31:0] later();
        clock_ms = clock_ms + {16'd0, m_interval} + 32'($urandom_range(0, 50));
        return clock_ms;
    endfunction

    task automatic test_reset_defaults();
        send_sample(32'd4999, 1'b1, 1'b1, 15'sd2000, 17'd51200);   // too early after reset
        send_sample(32'd5000, 1'b1, 1'b1, 15'sd2000, 17'd51200);
        clock_ms = 32'd5000;
    endtask

    task automatic test_error_paths();
        set_config(7'd50, 7'd127, 16'd0, 11'd400, 11'd200);
        send_sample(later(), 1'b0, 1'b1, 15'sd2000, 17'd51200);
        send_sample(later(), 1'b1, 1'b0, 15'sd2000, 17'd51200);
        send_sample(later(), 1'b1, 1'b1, 15'sd2000, 17'd0);
        send_sample(later(), 1'b1, 1'b1, 15'sd2000, 17'd102401);
        send_sample(later(), 1'b1, 1'b1, 15'sd2000, 17'd131071);
        send_sample(later(), 1'b1, 1'b1, 15'sd2000, 17'd102400);
    endtask

    task automatic test_field_extremes();
        set_config(7'd100, 7'd100, 16'd0, 11'd2047, 11'd0);
        send_sample(later(), 1'b1, 1'b1, 15'sd8500, 17'd1);
        send_sample(later(), 1'b1, 1'b1, -15'sd4000, 17'd102400);
        send_sample(later(), 1'b1, 1'b1, 15'sh3fff, 17'd50000);
        send_sample(later(), 1'b1, 1'b1, 15'sh4000, 17'd50000);
        send_sample(later(), 1'b1, 1'b1, 15'sh7fff, 17'd99999);
        send_sample(later(), 1'b1, 1'b1, 15'sd0, 17'd65536);
        send_sample(32'hffff_ffff, 1'b1, 1'b1, 15'sd1500, 17'd97000);
        clock_ms = 32'hffff_ffff;
    endtask

    task automatic test_interval_window();
        set_config(7'd80, 7'd30, 16'd65535, 11'd2000, 11'd1);
        clock_ms = m_last;
        send_sample(clock_ms + 32'd65534, 1'b1, 1'b1, 15'sd2500, 17'd95000);
        send_sample(clock_ms + 32'd65535, 1'b1, 1'b1, 15'sd2500, 17'd95000);
        send_sample(clock_ms + 32'd65535, 1'b1, 1'b1, 15'sd2500, 17'd95000);
        clock_ms = m_last;
    endtask

    task automatic test_random_samples(int count);
        logic [31:0] now;
        logic [16:0] hum;
        int          sel;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
                set_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                           ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 200)),
                           11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
            if (i % 400 == 200)
                drain();    // sender holds off until all results are in
            sel = $urandom_range(0, 19);
            if (sel == 0)
                now = $urandom;
            else if (sel < 3)
                now = clock_ms + $urandom_range(0, {16'd0, m_interval});
            else
                now = later();
            clock_ms = now;
            hum = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(1, 102400));
            send_sample(now, $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0,
                        ($urandom_range(0, 9) == 0) ? 15'($urandom)
                                                    : 15'($urandom_range(0, 12500) - 4000),
                        hum);
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.now_ms = '0;
        in_ch.sensor_present = 1'b0;
        in_ch.reading_valid = 1'b0;
        in_ch.temperature = '0;
        in_ch.humidity = '0;
        m_h1_lim = '0;
        m_h2_lim = '0;
        m_interval = dhpc_pkg::INTERVAL_RESET;
        m_start = dhpc_pkg::START_RESET;
        m_full = dhpc_pkg::FULL_ON_RESET;
        m_last = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_error_paths();
        test_field_extremes();
        test_interval_window();
        test_random_samples(1330);
        drain();
        $display("Sent %0d samples over several register settings; %0d results checked.",
                 samples_sent, results_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
